// ===== src/hdu_pkg.sv =====
// Package for the haversine distance unit: constants, types and helper functions.
package hdu_pkg;

    localparam int ANGLE_W = 34;
    localparam int CW = 34;
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
    localparam logic signed [27:0] FULL_TURN = 28'sd47185920;
    localparam logic signed [27:0] HALF_TURN = 28'sd23592960;
    localparam logic signed [27:0] QUARTER_TURN = 28'sd11796480;
    localparam logic [32:0] DEG2RAD_Q36 = 33'd1199381129;
    localparam logic [22:0] DIST_MAX = 23'd6588397;
    localparam logic [20:0] RADIUS_RESET = 21'd1013453;

    typedef logic signed [CW-1:0] cword_t;

    function automatic cword_t atan_entry(input int i);
        cword_t r;
        begin
            case (i)
                0: r = 34'sd843314856;
                1: r = 34'sd497837829;
                2: r = 34'sd263043836;
                3: r = 34'sd133525158;
                4: r = 34'sd67021686;
                5: r = 34'sd33543515;
                6: r = 34'sd16775850;
                7: r = 34'sd8388437;
                8: r = 34'sd4194282;
                9: r = 34'sd2097149;
                10: r = 34'sd1048575;
                11: r = 34'sd524287;
                12: r = 34'sd262143;
                13: r = 34'sd131071;
                14: r = 34'sd65535;
                15: r = 34'sd32767;
                16: r = 34'sd16383;
                17: r = 34'sd8191;
                18: r = 34'sd4095;
                19: r = 34'sd2047;
                20: r = 34'sd1023;
                21: r = 34'sd511;
                22: r = 34'sd255;
                23: r = 34'sd127;
                24: r = 34'sd63;
                25: r = 34'sd31;
                26: r = 34'sd15;
                27: r = 34'sd7;
                28: r = 34'sd3;
                29: r = 34'sd1;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== src/hdu_cordic_stage.sv =====
// One registered CORDIC micro-rotation, rotation or vectoring mode.
module hdu_cordic_stage
    import hdu_pkg::*;
#(
    parameter int STEP = 0,
    parameter bit VECTOR = 1'b0
)
(
    input  logic   clk,
    input  logic   en,
    input  cword_t x_in,
    input  cword_t y_in,
    input  cword_t z_in,
    output cword_t x_out,
    output cword_t y_out,
    output cword_t z_out
);

    cword_t x_next, y_next, z_next;
    cword_t x_reg, y_reg, z_reg;
    logic   pos;

    always_comb
    begin
        // rotation steers on the residual angle, vectoring on y
        pos = VECTOR ? (y_in >= 0) : (z_in >= 0);
        if (pos != VECTOR)
        begin
            x_next = x_in - (y_in >>> STEP);
            y_next = y_in + (x_in >>> STEP);
            z_next = z_in - atan_entry(STEP);
        end
        else
        begin
            x_next = x_in + (y_in >>> STEP);
            y_next = y_in - (x_in >>> STEP);
            z_next = z_in + atan_entry(STEP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// ===== src/haversine_distance_unit_core.sv =====
// Top level of the haversine distance unit: a fully pipelined great-circle distance datapath.
// Throughput: one transaction per cycle; the whole pipeline advances together and
// holds when the output register is full and not taken, so a stall loses nothing.
// The root stages compute one result bit each; the CORDIC chains take one step per stage.
// Reset clears the valid bits and loads radius_reg with 3958.8 miles.
module haversine_distance_unit_core
    import hdu_pkg::*;
#(
    parameter int CORDIC_STEPS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [20:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // first_latitude[23:0], first_longitude[48:24], second_latitude[72:49],
    // second_longitude[97:73], zero pad [103:98]
    input  logic [103:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // distance[22:0], zero pad [23]
    output logic [23:0] m_axis_tdata
);

    localparam int RED = 4;              // reduction and scaling stages
    localparam int MUL = 5;              // products forming a
    localparam int SQ = 32;              // bit-per-stage roots
    localparam int FIN = 3;              // radius multiply and saturation
    localparam int DEPTH = RED + CORDIC_STEPS + MUL + SQ + CORDIC_STEPS + FIN;

    logic [20:0] radius_reg;
    logic [DEPTH-1:0] vld_reg;
    logic adv;

    // Advance whenever the last stage can empty.
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                radius_reg <= cfg_wdata;
            if (adv)
                vld_reg <= {vld_reg[DEPTH-2:0], s_axis_tvalid};
        end
    end

    // ---------------- reduction: four angles in 2^-17 degree ----------------
    logic signed [27:0] ang_in [4];
    always_comb
    begin
        ang_in[0] = 28'(signed'(s_axis_tdata[72:49])) - 28'(signed'(s_axis_tdata[23:0]));
        ang_in[1] = 28'(signed'(s_axis_tdata[97:73])) - 28'(signed'(s_axis_tdata[48:24]));
        ang_in[2] = 28'(signed'({s_axis_tdata[23:0], 1'b0}));
        ang_in[3] = 28'(signed'({s_axis_tdata[72:49], 1'b0}));
    end

    logic signed [27:0] m0_reg [4];
    logic signed [27:0] m1_reg [4];
    logic [3:0] flip2_reg, neg2_reg, flip3_reg;
    logic [24:0] mag2_reg [4];
    logic [57:0] prod3_reg [4];
    cword_t cx [4][CORDIC_STEPS+1];
    cword_t cy [4][CORDIC_STEPS+1];
    cword_t cz [4][CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0] cflip [4];

    for (genvar k = 0; k < 4; k++)
    begin : g_red
        logic signed [27:0] wrapped, m1, folded;
        logic fl;
        always_comb
        begin
            // inputs span under two turns either way
            wrapped = m0_reg[k];
            if (wrapped >= HALF_TURN)
                wrapped = wrapped - FULL_TURN;
            else if (wrapped < -HALF_TURN)
                wrapped = wrapped + FULL_TURN;
            if (wrapped >= HALF_TURN)
                wrapped = wrapped - FULL_TURN;
            else if (wrapped < -HALF_TURN)
                wrapped = wrapped + FULL_TURN;
            m1 = wrapped;
            fl = 1'b0;
            folded = m1_reg[k];
            if (m1_reg[k] > QUARTER_TURN)
            begin
                folded = HALF_TURN - m1_reg[k];
                fl = 1'b1;
            end
            else if (m1_reg[k] < -QUARTER_TURN)
            begin
                folded = -HALF_TURN - m1_reg[k];
                fl = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                m0_reg[k] <= ang_in[k];
                m1_reg[k] <= m1;
                neg2_reg[k] <= folded < 0;
                mag2_reg[k] <= 25'(folded < 0 ? -folded : folded);
                flip2_reg[k] <= fl;
                prod3_reg[k] <= 58'(mag2_reg[k]) * 58'(DEG2RAD_Q36) + 58'd4194304;
                flip3_reg[k] <= flip2_reg[k];
            end
        end

        // stage 3 feeds the CORDIC chain through the sign of the angle
        logic [34:0] rmag;
        logic neg3_reg;
        always_ff @(posedge clk)
        begin
            if (adv)
                neg3_reg <= neg2_reg[k];
        end
        assign rmag = prod3_reg[k][57:23];
        assign cx[k][0] = GAIN_Q30;
        assign cy[k][0] = '0;
        assign cz[k][0] = neg3_reg ? -cword_t'(rmag) : cword_t'(rmag);
        assign cflip[k][0] = flip3_reg[k];

        for (genvar i = 0; i < CORDIC_STEPS; i++)
        begin : g_rot
            logic fl_reg;
            hdu_cordic_stage #(.STEP(i), .VECTOR(1'b0)) u_rot (
                .clk   (clk),
                .en    (adv),
                .x_in  (cx[k][i]),
                .y_in  (cy[k][i]),
                .z_in  (cz[k][i]),
                .x_out (cx[k][i+1]),
                .y_out (cy[k][i+1]),
                .z_out (cz[k][i+1])
            );
            always_ff @(posedge clk)
            begin
                if (adv)
                    fl_reg <= cflip[k][i];
            end
            assign cflip[k][i+1] = fl_reg;
        end
    end

    // ---------------- forming a ----------------
    cword_t s_dlat, s_dlon, c1, c2;
    assign s_dlat = cy[0][CORDIC_STEPS];
    assign s_dlon = cy[1][CORDIC_STEPS];
    assign c1 = cflip[2][CORDIC_STEPS] ? -cx[2][CORDIC_STEPS] : cx[2][CORDIC_STEPS];
    assign c2 = cflip[3][CORDIC_STEPS] ? -cx[3][CORDIC_STEPS] : cx[3][CORDIC_STEPS];

    logic signed [67:0] t_prod_reg, sl_prod_reg, so_prod_reg, u_prod_reg;
    cword_t t_reg, sl_reg, so_reg, sl2_reg, sl3_reg, u_reg;
    logic [30:0] a_reg;
    logic signed [35:0] a_sum;

    always_comb
    begin
        a_sum = 36'(sl3_reg) + 36'(u_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_prod_reg <= 68'(c1) * 68'(c2);
            sl_prod_reg <= 68'(s_dlat) * 68'(s_dlat);
            so_prod_reg <= 68'(s_dlon) * 68'(s_dlon);
            t_reg <= CW'(t_prod_reg >>> 30);
            sl_reg <= CW'(sl_prod_reg >>> 30);
            so_reg <= CW'(so_prod_reg >>> 30);
            u_prod_reg <= 68'(so_reg) * 68'(t_reg);
            sl2_reg <= sl_reg;
            u_reg <= CW'(u_prod_reg >>> 30);
            sl3_reg <= sl2_reg;
            if (a_sum < 0)
                a_reg <= '0;
            else if (a_sum > 36'(ONE_Q30))
                a_reg <= 31'(ONE_Q30);
            else
                a_reg <= 31'(a_sum);
        end
    end

    // ---------------- two floor square roots, one bit per stage ----------------
    logic [63:0] ra [SQ+1];
    logic [63:0] va [SQ+1];
    logic [63:0] rb [SQ+1];
    logic [63:0] vb [SQ+1];
    assign ra[0] = '0;
    assign rb[0] = '0;
    assign va[0] = {3'd0, a_reg, 30'd0};
    assign vb[0] = {3'd0, 31'(ONE_Q30) - a_reg, 30'd0};

    for (genvar k = 0; k < SQ; k++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] ra_reg, va_reg, rb_reg, vb_reg;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (va[k] >= ra[k] + BIT)
                begin
                    va_reg <= va[k] - (ra[k] + BIT);
                    ra_reg <= (ra[k] >> 1) + BIT;
                end
                else
                begin
                    va_reg <= va[k];
                    ra_reg <= ra[k] >> 1;
                end
                if (vb[k] >= rb[k] + BIT)
                begin
                    vb_reg <= vb[k] - (rb[k] + BIT);
                    rb_reg <= (rb[k] >> 1) + BIT;
                end
                else
                begin
                    vb_reg <= vb[k];
                    rb_reg <= rb[k] >> 1;
                end
            end
        end
        assign ra[k+1] = ra_reg;
        assign va[k+1] = va_reg;
        assign rb[k+1] = rb_reg;
        assign vb[k+1] = vb_reg;
    end

    // ---------------- vectoring CORDIC ----------------
    cword_t vx [CORDIC_STEPS+1];
    cword_t vy [CORDIC_STEPS+1];
    cword_t vz [CORDIC_STEPS+1];
    assign vx[0] = cword_t'(rb[SQ][31:0]);
    assign vy[0] = cword_t'(ra[SQ][31:0]);
    assign vz[0] = '0;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_vec
        hdu_cordic_stage #(.STEP(i), .VECTOR(1'b1)) u_vec (
            .clk   (clk),
            .en    (adv),
            .x_in  (vx[i]),
            .y_in  (vy[i]),
            .z_in  (vz[i]),
            .x_out (vx[i+1]),
            .y_out (vy[i+1]),
            .z_out (vz[i+1])
        );
    end

    // ---------------- radius scaling and saturation ----------------
    cword_t zf;
    logic [30:0] z_reg;
    logic [51:0] d_prod_reg;
    logic [22:0] dist_reg;
    logic [22:0] d_prod_hi;
    assign zf = vz[CORDIC_STEPS];
    assign d_prod_hi = d_prod_reg[51:29] ;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z_reg <= zf < 0 ? '0 : 31'(zf);
            d_prod_reg <= 52'(radius_reg) * 52'(z_reg) + 52'd268435456;
            dist_reg <= (d_prod_hi > DIST_MAX) ? DIST_MAX : d_prod_hi;
        end
    end

    assign m_axis_tvalid = vld_reg[DEPTH-1];
    assign m_axis_tdata = {1'b0, dist_reg};

endmodule
